// ----- src/chained_xor_packet_codec_unit_assert.svh -----
// Assertion macros used by the packet codec top level.
`ifndef CHAINED_XOR_PACKET_CODEC_UNIT_ASSERT_SVH
`define CHAINED_XOR_PACKET_CODEC_UNIT_ASSERT_SVH

// Implication in the same cycle, disabled while reset is held.
`define CXPC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("codec assertion failed");

// Implication checked in the next cycle, disabled while reset is held.
`define CXPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("codec assertion failed");

`endif

// ----- src/cxpc_pkg.sv -----
// Package of shared types for the chained XOR packet codec.
package cxpc_pkg;

    localparam int unsigned ByteW = 8;

    typedef struct packed {
        logic             func;
        logic             first_byte;
        logic             last_byte;
        logic [ByteW-1:0] packet_rand_key;
        logic [ByteW-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             out_last;
        logic             checksum_ok;
    } result_t;

endpackage

// ----- src/cxpc_datapath.sv -----
// Chain state and the combinational encode and decode transform of one byte.
module cxpc_datapath
    import cxpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [ByteW-1:0] fixed_key,
    input  item_t            item,
    input  logic             commit,
    output result_t          result
);

    logic [ByteW-1:0] prev_plain_reg, prev_plain_next;
    logic [ByteW-1:0] prev_cipher_reg, prev_cipher_next;
    logic [ByteW-1:0] position_reg, position_next;
    logic [ByteW-1:0] payload_sum_reg, payload_sum_next;
    logic [ByteW-1:0] expected_sum_reg, expected_sum_next;

    logic [ByteW-1:0] base_plain, base_cipher, base_position;
    logic [ByteW-1:0] inner_pad, outer_pad, mid, cipher, plain_out;

    always_comb begin
        base_plain    = item.first_byte ? '0 : prev_plain_reg;
        base_cipher   = item.first_byte ? '0 : prev_cipher_reg;
        base_position = item.first_byte ? '0 : position_reg;

        inner_pad = base_plain + item.packet_rand_key + base_position + ByteW'(1);
        outer_pad = base_cipher + fixed_key + base_position + ByteW'(1);

        if (item.func) begin
            cipher    = item.data_byte;
            mid       = item.data_byte ^ outer_pad;
            plain_out = mid ^ inner_pad;
        end else begin
            mid       = item.data_byte ^ inner_pad;
            cipher    = mid ^ outer_pad;
            plain_out = cipher;
        end

        payload_sum_next  = payload_sum_reg;
        expected_sum_next = expected_sum_reg;
        if (item.func) begin
            if (item.first_byte) begin
                payload_sum_next  = '0;
                expected_sum_next = plain_out;
            end else begin
                payload_sum_next = payload_sum_reg + plain_out;
            end
        end

        prev_plain_next  = mid;
        prev_cipher_next = cipher;
        position_next    = base_position + ByteW'(1);

        result.out_byte    = plain_out;
        result.out_last    = item.last_byte;
        result.checksum_ok = item.func && item.last_byte
                             && (payload_sum_next == expected_sum_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_plain_reg   <= '0;
            prev_cipher_reg  <= '0;
            position_reg     <= '0;
            payload_sum_reg  <= '0;
            expected_sum_reg <= '0;
        end else if (commit) begin
            prev_plain_reg   <= prev_plain_next;
            prev_cipher_reg  <= prev_cipher_next;
            position_reg     <= position_next;
            payload_sum_reg  <= payload_sum_next;
            expected_sum_reg <= expected_sum_next;
        end
    end

endmodule

// ----- src/chained_xor_packet_codec_unit.sv -----
// Top level of the chained XOR packet codec with stream ports.
// An accepted input transaction waits in the input register; its result is offered from
// the result register. Throughput: one byte per cycle unless m_tready stalls the output;
// the chain state updates as each byte moves from the input into the result register.
// Reset (aresetn low at a clock edge) empties both registers, sets the chains,
// position, sums and the fixed key to zero.
`include "chained_xor_packet_codec_unit_assert.svh"

module chained_xor_packet_codec_unit
    import cxpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // packet_rand_key [7:0], data_byte [15:8]
    input  logic             s_tlast,
    input  logic [1:0]       s_tuser,   // func [0], first_byte [1]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte [7:0]
    output logic             m_tlast,
    output logic [0:0]       m_tuser,   // checksum_ok [0]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ByteW-1:0] cfg_data
);

    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    result_t          out_result_reg;
    logic [ByteW-1:0] fixed_key_reg;

    logic    out_ready;
    logic    advance;
    result_t result;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    cxpc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fixed_key (fixed_key_reg),
        .item      (in_item_reg),
        .commit    (advance),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fixed_key_reg <= '0;
        end else begin
            if (cfg_valid) begin
                fixed_key_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.func            <= s_tuser[0];
            in_item_reg.first_byte      <= s_tuser[1];
            in_item_reg.last_byte       <= s_tlast;
            in_item_reg.packet_rand_key <= s_tdata[7:0];
            in_item_reg.data_byte       <= s_tdata[15:8];
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_result_reg.out_byte;
    assign m_tlast    = out_result_reg.out_last;
    assign m_tuser[0] = out_result_reg.checksum_ok;

    `CXPC_ASSERT_NEXT(a_accept_fills_input, aclk, aresetn, s_tvalid && s_tready, in_valid_reg)
    `CXPC_ASSERT_NEXT(a_stalled_item_kept, aclk, aresetn, in_valid_reg && !out_ready,
                      in_valid_reg && out_valid_reg)
    `CXPC_ASSERT_NEXT(a_advance_offers_result, aclk, aresetn, advance, m_tvalid)
    `CXPC_ASSERT_SAME(a_ok_only_on_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the chained XOR packet codec: directed table, then random packets.
`timescale 1ns / 1ps

module tb_top;
    import cxpc_pkg::*;

    localparam logic FuncEncode = 1'b0;
    localparam logic FuncDecode = 1'b1;
    localparam int   CycleLimit = 200000;
    localparam int   DrainCycles = 10;

    typedef struct packed {
        logic [7:0] prev_mid;
        logic [7:0] prev_cipher;
        logic [7:0] pos;
        logic [7:0] payload_sum;
        logic [7:0] checksum;
    } chain_t;

    typedef struct packed {
        logic       func;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] rkey;
        logic [7:0] data;
        logic       known;
        logic [7:0] out_byte;
        logic       out_last;
        logic       checksum_ok;
    } dir_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;   // packet_rand_key [7:0], data_byte [15:8]
    logic             s_tlast = 1'b0;
    logic [1:0]       s_tuser = '0;   // func [0], first_byte [1]
    logic             m_tvalid;
    logic             m_tready = 1'b1;
    logic [7:0]       m_tdata;        // out_byte [7:0]
    logic             m_tlast;
    logic [0:0]       m_tuser;        // checksum_ok [0]
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [ByteW-1:0] cfg_data = '0;

    chain_t     chain_state = '0;
    logic [7:0] fixed_key_shadow = '0;
    result_t    expected_results [$];
    int         errors = 0;
    int         cycles = 0;
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    int         bytes_sent = 0;
    dir_row_t   dir_rows [16];

    chained_xor_packet_codec_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic result_t codec_predict(inout chain_t st, input item_t it,
                                              input logic [7:0] key);
        logic [7:0] inner_pad;
        logic [7:0] outer_pad;
        logic [7:0] mid;
        logic [7:0] cipher;
        result_t    res;
        res = '0;
        if (it.first_byte) begin
            st.prev_mid = '0;
            st.prev_cipher = '0;
            st.pos = '0;
        end
        inner_pad = st.prev_mid + it.packet_rand_key + st.pos + 8'd1;
        outer_pad = st.prev_cipher + key + st.pos + 8'd1;
        if (it.func == FuncDecode) begin
            cipher = it.data_byte;
            mid = cipher ^ outer_pad;
            res.out_byte = mid ^ inner_pad;
            if (it.first_byte) begin
                st.checksum = res.out_byte;
                st.payload_sum = '0;
            end else begin
                st.payload_sum = st.payload_sum + res.out_byte;
            end
            if (it.last_byte)
                res.checksum_ok = (st.payload_sum == st.checksum);
        end else begin
            mid = it.data_byte ^ inner_pad;
            cipher = mid ^ outer_pad;
            res.out_byte = cipher;
        end
        res.out_last = it.last_byte;
        st.prev_mid = mid;
        st.prev_cipher = cipher;
        st.pos = st.pos + 8'd1;
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                errors = errors + 1;
                $display("%0t: result with no expectation: byte %h last %b ok %b",
                         $time, m_tdata, m_tlast, m_tuser[0]);
            end else begin
                want = expected_results.pop_front();
                if (want.out_byte !== m_tdata) begin
                    errors = errors + 1;
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want.out_byte, m_tdata);
                end
                if (want.out_last !== m_tlast) begin
                    errors = errors + 1;
                    $display("%0t: out_last expected %b actual %b", $time,
                             want.out_last, m_tlast);
                end
                if (want.checksum_ok !== m_tuser[0]) begin
                    errors = errors + 1;
                    $display("%0t: checksum_ok expected %b actual %b", $time,
                             want.checksum_ok, m_tuser[0]);
                end
            end
        end
    end

    task automatic send_item(input item_t it, input logic known, input result_t typed);
        result_t pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.data_byte, it.packet_rand_key};
        s_tuser <= {it.first_byte, it.func};
        s_tlast <= it.last_byte;
        do @(posedge aclk); while (!s_tready);
        pred = codec_predict(chain_state, it, fixed_key_shadow);
        expected_results.push_back(known ? typed : pred);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic func, input logic first, input logic last,
                             input logic [7:0] rkey, input logic [7:0] data);
        item_t it;
        it.func = func;
        it.first_byte = first;
        it.last_byte = last;
        it.packet_rand_key = rkey;
        it.data_byte = data;
        send_item(it, 1'b0, '0);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_fixed_key(input logic [7:0] key);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= key;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fixed_key_shadow = key;
    endtask

    // A decode packet is built from a well-formed plain packet encoded with a private chain.
    task automatic send_packet(input logic func, input int payload_len, input logic corrupt);
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] rkey;
        chain_t     scratch;
        item_t      it;
        result_t    enc;
        int         hit;
        sum = '0;
        rkey = 8'($urandom);
        scratch = '0;
        body.push_back(8'h00);
        for (int i = 0; i < payload_len; i++) begin
            body.push_back(8'($urandom));
            sum = sum + body[i + 1];
        end
        body[0] = sum;
        if (func == FuncDecode) begin
            for (int i = 0; i < body.size(); i++) begin
                it.func = FuncEncode;
                it.first_byte = (i == 0);
                it.last_byte = (i == body.size() - 1);
                it.packet_rand_key = rkey;
                it.data_byte = body[i];
                enc = codec_predict(scratch, it, fixed_key_shadow);
                body[i] = enc.out_byte;
            end
            if (corrupt) begin
                hit = $urandom_range(body.size() - 1);
                body[hit] = body[hit] ^ 8'(1 << $urandom_range(7));
            end
        end
        for (int i = 0; i < body.size(); i++)
            send_byte(func, i == 0, i == body.size() - 1, rkey, body[i]);
    endtask

    task automatic run_random(input int n_items);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_packet(FuncEncode, $urandom_range(12), 1'b0);
            else if (pick < 80)
                send_packet(FuncDecode, $urandom_range(12), $urandom_range(9) == 0);
            else
                repeat ($urandom_range(1, 5))
                    send_byte(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        item_t   it;
        result_t typed;
        dir_rows = '{
            '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
            '{1'b0, 1'b0, 1'b1, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1},
            '{1'b1, 1'b1, 1'b1, 8'hFF, 8'h00, 1'b1, 8'h01, 1'b1, 1'b0},
            '{1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1, 8'hFE, 1'b1, 1'b0},
            '{1'b0, 1'b0, 1'b0, 8'h55, 8'hAA, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b1, 1'b0, 1'b1, 8'h55, 8'hAA, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b1, 1'b1, 1'b0, 8'hA5, 8'h3C, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b0, 1'b0, 1'b0, 8'hA5, 8'hC3, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b1, 1'b0, 1'b0, 8'hA5, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b0, 1'b0, 1'b1, 8'hA5, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b1, 1'b1, 1'b0, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b1, 1'b0, 1'b0, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b0, 1'b1, 1'b0, 8'h80, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0},
            '{1'b0, 1'b0, 1'b1, 8'h7F, 8'hFE, 1'b0, 8'h00, 1'b0, 1'b0}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            it.func = dir_rows[i].func;
            it.first_byte = dir_rows[i].first_byte;
            it.last_byte = dir_rows[i].last_byte;
            it.packet_rand_key = dir_rows[i].rkey;
            it.data_byte = dir_rows[i].data;
            typed.out_byte = dir_rows[i].out_byte;
            typed.out_last = dir_rows[i].out_last;
            typed.checksum_ok = dir_rows[i].checksum_ok;
            send_item(it, dir_rows[i].known, typed);
        end

        write_fixed_key(8'hFF);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        run_random(50);

        write_fixed_key(8'h00);
        src_idle_pct = 72;
        run_random(50);

        write_fixed_key(8'($urandom));
        src_idle_pct = 0;
        snk_stall_pct = 72;
        run_random(50);

        write_fixed_key(8'($urandom));
        src_idle_pct = 19;
        snk_stall_pct = 19;
        run_random(50);

        // The position counter wraps within this packet.
        write_fixed_key(8'h80);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_packet(FuncDecode, 257, 1'b0);
        send_packet(FuncEncode, 3, 1'b0);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/cxpc_pkg.sv
src/cxpc_datapath.sv
src/chained_xor_packet_codec_unit.sv
tb/tb_top.sv
